// ===== design/foc_park_clarke_svpwm_top_macros.svh =====
// assertion macros shared by the foc transform rtl
`ifndef FOC_PARK_CLARKE_SVPWM_TOP_MACROS_SVH
`define FOC_PARK_CLARKE_SVPWM_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define FPCS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpcs assertion failed");

// next-cycle implication, disabled while reset is high
`define FPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpcs assertion failed");

`endif

// ===== design/fpcs_pkg.sv =====
// shared constants and the arctangent function of the foc transform block
`timescale 1ns / 1ps
`default_nettype none
package fpcs_pkg;

   localparam int ANGLE_BITS_DEFAULT = 18;
   localparam int DATA_BITS_DEFAULT  = 16;

   // csr map
   localparam int          CSR_ADDR_BITS      = 5;
   localparam logic [2:0]  REG_ZERO_ANGLE     = 3'd0;
   localparam logic [2:0]  REG_DIRECTION      = 3'd1;
   localparam logic [2:0]  REG_U_OFFSET       = 3'd2;
   localparam logic [2:0]  REG_V_OFFSET       = 3'd3;
   localparam logic [2:0]  REG_POLE_PAIRS     = 3'd4;
   localparam logic [2:0]  REG_PWM_PERIOD     = 3'd5;
   localparam logic [6:0]  POLE_PAIRS_RESET   = 7'd7;
   localparam logic [15:0] PWM_PERIOD_RESET   = 16'd4250;

   // cordic in q4.30 with a 32-bit turn angle
   localparam int                 CORDIC_STEPS = 16;
   localparam int                 CORDIC_W     = 34;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

   // 1/sqrt3 and sqrt3 in q.16
   localparam logic signed [18:0] INV_SQRT3_Q16 = 19'sd37837;
   localparam logic signed [18:0] SQRT3_Q16     = 19'sd113512;

   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
      logic signed [CORDIC_W-1:0] val;
      case (step)
         0:       val = 34'sd536870912;
         1:       val = 34'sd316933406;
         2:       val = 34'sd167458908;
         3:       val = 34'sd85004756;
         4:       val = 34'sd42667341;
         5:       val = 34'sd21354465;
         6:       val = 34'sd10679844;
         7:       val = 34'sd5340245;
         8:       val = 34'sd2670163;
         9:       val = 34'sd1335087;
         10:      val = 34'sd667544;
         11:      val = 34'sd333772;
         12:      val = 34'sd166886;
         13:      val = 34'sd83443;
         14:      val = 34'sd41721;
         15:      val = 34'sd20861;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ===== design/foc_park_clarke_svpwm_top.sv =====
// top level of the foc transform block: csr bank and pipeline
//
//  channel   dir   handshake                fields
//  req_*     in    req_valid / req_ready    mech_angle, phase_u/v_current, volt_d/q
//  rsp_*     out   rsp_valid / rsp_ready    elec_angle, current_d/q, duty_a/b/c
//  csr       in    psel, penable, pwrite    paddr, pwdata, prdata, pready
//
// 27 register stages: 3 front stages, 16 cordic stages (one rotation step
// each) and 8 transform stages; rsp_valid rises when an accepted request
// leaves the last transform stage. one transaction is accepted every cycle
// while the pipeline is not frozen; the whole pipeline advances together
// and freezes only while rsp_valid is high and rsp_ready is low.
// reset clears the valid bits and loads the csr reset values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "foc_park_clarke_svpwm_top_macros.svh"
module foc_park_clarke_svpwm_top #(
   parameter int ANGLE_BITS = fpcs_pkg::ANGLE_BITS_DEFAULT,
   parameter int DATA_BITS  = fpcs_pkg::DATA_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input transactions
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [ANGLE_BITS-1:0]               req_mech_angle,
   input  wire logic signed [DATA_BITS-1:0]         req_phase_u_current,
   input  wire logic signed [DATA_BITS-1:0]         req_phase_v_current,
   input  wire logic signed [DATA_BITS-1:0]         req_volt_d,
   input  wire logic signed [DATA_BITS-1:0]         req_volt_q,
   // result transactions
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ANGLE_BITS-1:0]                    rsp_elec_angle,
   output logic signed [DATA_BITS:0]                rsp_current_d,
   output logic signed [DATA_BITS:0]                rsp_current_q,
   output logic [15:0]                              rsp_duty_a,
   output logic [15:0]                              rsp_duty_b,
   output logic [15:0]                              rsp_duty_c,
   // csr port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [fpcs_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import fpcs_pkg::*;

   localparam int AW = ANGLE_BITS;
   localparam int DW = DATA_BITS;
   // side band carried along the cordic: flip, elec, iu, ibp, ud, uq
   localparam int SIDE_W = 1 + AW + (DW + 1) + (DW + 22) + DW + DW;

   // csr bank
   logic [AW-1:0]        zero_angle_ff;
   logic                 direction_ff;
   logic signed [DW-1:0] u_bias_ff;
   logic signed [DW-1:0] v_bias_ff;
   logic [6:0]           pole_pairs_ff;
   logic [15:0]          pwm_period_ff;
   logic                 csr_write;
   logic [2:0]           csr_index;

   // pipeline enable: everything moves unless a result is stuck at the output
   logic en;

   // front to cordic
   logic                       f_valid, f_flip;
   logic [AW-1:0]              f_elec;
   logic signed [CORDIC_W-1:0] f_z;
   logic signed [DW:0]         f_iu;
   logic signed [DW+21:0]      f_ibp;
   logic signed [DW-1:0]       f_ud, f_uq;
   logic [SIDE_W-1:0]          side_in, side_out;

   // cordic to transforms
   logic                       c_valid;
   logic signed [CORDIC_W-1:0] c_x, c_y;
   logic                       c_flip;
   logic [AW-1:0]              c_elec;
   logic signed [DW:0]         c_iu;
   logic signed [DW+21:0]      c_ibp;
   logic signed [DW-1:0]       c_ud, c_uq;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_angle_ff <= '0;
         direction_ff  <= 1'b0;
         u_bias_ff     <= '0;
         v_bias_ff     <= '0;
         pole_pairs_ff <= POLE_PAIRS_RESET;
         pwm_period_ff <= PWM_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ZERO_ANGLE: zero_angle_ff <= pwdata[AW-1:0];
            REG_DIRECTION:  direction_ff  <= pwdata[0];
            REG_U_OFFSET:   u_bias_ff     <= pwdata[DW-1:0];
            REG_V_OFFSET:   v_bias_ff     <= pwdata[DW-1:0];
            REG_POLE_PAIRS: pole_pairs_ff <= pwdata[6:0];
            REG_PWM_PERIOD: pwm_period_ff <= pwdata[15:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (csr_index)
         REG_ZERO_ANGLE: prdata = 32'(zero_angle_ff);
         REG_DIRECTION:  prdata = 32'(direction_ff);
         REG_U_OFFSET:   prdata = 32'($unsigned(u_bias_ff));
         REG_V_OFFSET:   prdata = 32'($unsigned(v_bias_ff));
         REG_POLE_PAIRS: prdata = 32'(pole_pairs_ff);
         REG_PWM_PERIOD: prdata = 32'(pwm_period_ff);
         default:        prdata = '0;
      endcase
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   fpcs_front #(.AW(AW), .DW(DW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .mech_angle (req_mech_angle),
      .iu_raw     (req_phase_u_current),
      .iv_raw     (req_phase_v_current),
      .ud         (req_volt_d),
      .uq         (req_volt_q),
      .zero_angle (zero_angle_ff),
      .dir_pos    (direction_ff),
      .u_off      (u_bias_ff),
      .v_off      (v_bias_ff),
      .pole_pairs (pole_pairs_ff),
      .out_valid  (f_valid),
      .elec       (f_elec),
      .z_start    (f_z),
      .flip       (f_flip),
      .iu         (f_iu),
      .ibp        (f_ibp),
      .ud_o       (f_ud),
      .uq_o       (f_uq)
   );

   assign side_in = {f_flip, f_elec, f_iu, f_ibp, f_ud, f_uq};

   fpcs_cordic #(.SIDE_W(SIDE_W)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .z_start   (f_z),
      .side_in   (side_in),
      .out_valid (c_valid),
      .x_out     (c_x),
      .y_out     (c_y),
      .side_out  (side_out)
   );

   assign {c_flip, c_elec, c_iu, c_ibp, c_ud, c_uq} = side_out;

   fpcs_xform #(.AW(AW), .DW(DW)) u_xform (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (c_valid),
      .x_in       (c_x),
      .y_in       (c_y),
      .flip       (c_flip),
      .elec       (c_elec),
      .iu         (c_iu),
      .ibp        (c_ibp),
      .ud         (c_ud),
      .uq         (c_uq),
      .pwm_period (pwm_period_ff),
      .out_valid  (rsp_valid),
      .elec_o     (rsp_elec_angle),
      .id_o       (rsp_current_d),
      .iq_o       (rsp_current_q),
      .duty_a     (rsp_duty_a),
      .duty_b     (rsp_duty_b),
      .duty_c     (rsp_duty_c)
   );

   // pole pair write lands in the register
   `FPCS_ASSERT_NEXT(a_pole_write, clock, reset,
      csr_write && (csr_index == REG_POLE_PAIRS), pole_pairs_ff == $past(pwdata[6:0]))
   // no new transaction while a result is held at the output
   `FPCS_ASSERT_NOW(a_no_accept_stalled, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // pipeline comes out of reset empty
   `FPCS_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule
`default_nettype wire

// ===== design/fpcs_front.sv =====
// angle forming, current offset removal and beta current scaling
`timescale 1ns / 1ps
`default_nettype none
module fpcs_front #(
   parameter int AW = fpcs_pkg::ANGLE_BITS_DEFAULT,
   parameter int DW = fpcs_pkg::DATA_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic [AW-1:0]                        mech_angle,
   input  wire logic signed [DW-1:0]                 iu_raw,
   input  wire logic signed [DW-1:0]                 iv_raw,
   input  wire logic signed [DW-1:0]                 ud,
   input  wire logic signed [DW-1:0]                 uq,
   input  wire logic [AW-1:0]                        zero_angle,
   input  wire logic                                 dir_pos,
   input  wire logic signed [DW-1:0]                 u_off,
   input  wire logic signed [DW-1:0]                 v_off,
   input  wire logic [6:0]                           pole_pairs,
   output logic                                      out_valid,
   output logic [AW-1:0]                             elec,
   output logic signed [fpcs_pkg::CORDIC_W-1:0]      z_start,
   output logic                                      flip,
   output logic signed [DW:0]                        iu,
   output logic signed [DW+21:0]                     ibp,
   output logic signed [DW-1:0]                      ud_o,
   output logic signed [DW-1:0]                      uq_o
);
   import fpcs_pkg::*;

   logic [2:0] v_ff;

   // stage 0
   logic [AW-1:0]       base_ff, base_in;
   logic signed [DW:0]  iu0_ff, iu0_in, iv0_ff, iv0_in;
   logic signed [DW-1:0] ud0_ff, uq0_ff;
   // stage 1
   logic [AW+6:0]        elec_prod;
   logic [AW-1:0]        elec1_ff;
   logic signed [DW+2:0] isum_ff, isum_in;
   logic signed [DW:0]   iu1_ff;
   logic signed [DW-1:0] ud1_ff, uq1_ff;
   // stage 2
   logic [31:0]          turn;
   logic                 flip_in;
   logic [31:0]          turn_f;
   logic [AW-1:0]        elec2_ff;
   logic signed [CORDIC_W-1:0] z_ff;
   logic                 flip_ff;
   logic signed [DW:0]   iu2_ff;
   logic signed [DW+21:0] ibp_ff;
   logic signed [DW-1:0] ud2_ff, uq2_ff;

   assign base_in = dir_pos ? zero_angle + mech_angle : zero_angle - mech_angle;
   assign iu0_in  = $signed({iu_raw[DW-1], iu_raw}) - $signed({u_off[DW-1], u_off});
   assign iv0_in  = $signed({iv_raw[DW-1], iv_raw}) - $signed({v_off[DW-1], v_off});

   assign elec_prod = base_ff * pole_pairs;
   assign isum_in   = $signed({{2{iu0_ff[DW]}}, iu0_ff}) + $signed({iv0_ff[DW], iv0_ff, 1'b0});

   // fold the left half plane onto the right one, results get negated later
   assign turn    = {elec1_ff, {(32-AW){1'b0}}};
   assign flip_in = turn[31] ^ turn[30];
   assign turn_f  = {turn[31] ^ flip_in, turn[30:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff  <= base_in;
         iu0_ff   <= iu0_in;
         iv0_ff   <= iv0_in;
         ud0_ff   <= ud;
         uq0_ff   <= uq;
         elec1_ff <= elec_prod[AW-1:0];
         isum_ff  <= isum_in;
         iu1_ff   <= iu0_ff;
         ud1_ff   <= ud0_ff;
         uq1_ff   <= uq0_ff;
         elec2_ff <= elec1_ff;
         z_ff     <= $signed({{(CORDIC_W-32){turn_f[31]}}, turn_f});
         flip_ff  <= flip_in;
         iu2_ff   <= iu1_ff;
         ibp_ff   <= isum_ff * INV_SQRT3_Q16;
         ud2_ff   <= ud1_ff;
         uq2_ff   <= uq1_ff;
      end
   end

   assign out_valid = v_ff[2];
   assign elec      = elec2_ff;
   assign z_start   = z_ff;
   assign flip      = flip_ff;
   assign iu        = iu2_ff;
   assign ibp       = ibp_ff;
   assign ud_o      = ud2_ff;
   assign uq_o      = uq2_ff;

endmodule
`default_nettype wire

// ===== design/fpcs_cordic.sv =====
// pipelined rotation-mode cordic, one stage per step
`timescale 1ns / 1ps
`default_nettype none
module fpcs_cordic #(
   parameter int SIDE_W = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic signed [fpcs_pkg::CORDIC_W-1:0] z_start,
   input  wire logic [SIDE_W-1:0]                    side_in,
   output logic                                      out_valid,
   output logic signed [fpcs_pkg::CORDIC_W-1:0]      x_out,
   output logic signed [fpcs_pkg::CORDIC_W-1:0]      y_out,
   output logic [SIDE_W-1:0]                         side_out
);
   import fpcs_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_ff [CORDIC_STEPS];
   logic [SIDE_W-1:0]          side_ff [CORDIC_STEPS];
   logic [CORDIC_STEPS-1:0]    v_ff;

   logic signed [CORDIC_W-1:0] x_in [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_in [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_in [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_src, y_src, z_src;

   // one rotation step per stage, each fed by the stage before it
   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            x_src = CORDIC_GAIN;
            y_src = '0;
            z_src = z_start;
         end else begin
            x_src = x_ff[i-1];
            y_src = y_ff[i-1];
            z_src = z_ff[i-1];
         end
         if (!z_src[CORDIC_W-1]) begin
            x_in[i] = x_src - (y_src >>> i);
            y_in[i] = y_src + (x_src >>> i);
            z_in[i] = z_src - atan_turn(i);
         end else begin
            x_in[i] = x_src + (y_src >>> i);
            y_in[i] = y_src - (x_src >>> i);
            z_in[i] = z_src + atan_turn(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[CORDIC_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         side_ff[0] <= side_in;
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[CORDIC_STEPS-1];
   assign x_out     = x_ff[CORDIC_STEPS-1];
   assign y_out     = y_ff[CORDIC_STEPS-1];
   assign side_out  = side_ff[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ===== design/fpcs_xform.sv =====
// park, inverse park, inverse clarke, midpoint injection and duty scaling
`timescale 1ns / 1ps
`default_nettype none
`include "foc_park_clarke_svpwm_top_macros.svh"
module fpcs_xform #(
   parameter int AW = fpcs_pkg::ANGLE_BITS_DEFAULT,
   parameter int DW = fpcs_pkg::DATA_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic signed [fpcs_pkg::CORDIC_W-1:0] x_in,
   input  wire logic signed [fpcs_pkg::CORDIC_W-1:0] y_in,
   input  wire logic                                 flip,
   input  wire logic [AW-1:0]                        elec,
   input  wire logic signed [DW:0]                   iu,
   input  wire logic signed [DW+21:0]                ibp,
   input  wire logic signed [DW-1:0]                 ud,
   input  wire logic signed [DW-1:0]                 uq,
   input  wire logic [15:0]                          pwm_period,
   output logic                                      out_valid,
   output logic [AW-1:0]                             elec_o,
   output logic signed [DW:0]                        id_o,
   output logic signed [DW:0]                        iq_o,
   output logic [15:0]                               duty_a,
   output logic [15:0]                               duty_b,
   output logic [15:0]                               duty_c
);
   import fpcs_pkg::*;

   localparam int FRAC = DW - 1;
   localparam int SH   = 30 - FRAC;
   localparam int PW   = 2 * DW + 2;
   localparam int VW   = DW + 4;
   localparam int STAGES = 8;

   localparam logic signed [CORDIC_W-1:0] CHALF = CORDIC_W'(64'sd1 <<< (SH - 1));
   localparam logic signed [CORDIC_W-1:0] CLIMP = CORDIC_W'((64'sd1 <<< FRAC) - 1);
   localparam logic signed [CORDIC_W-1:0] CLIMN = CORDIC_W'(-(64'sd1 <<< FRAC));
   localparam logic signed [DW+21:0]      BHALF = (DW+22)'(64'sd1 <<< 15);
   localparam logic signed [PW:0]         PHALF = (PW+1)'(64'sd1 <<< (FRAC - 1));
   localparam logic signed [PW:0]         ILIMP = (PW+1)'((64'sd1 <<< DW) - 1);
   localparam logic signed [PW:0]         ILIMN = (PW+1)'(-(64'sd1 <<< DW));
   localparam logic signed [DW+20:0]      SHALF = (DW+21)'(64'sd1 <<< 15);
   localparam logic signed [VW:0]         VHALF = (VW+1)'(64'sd1 <<< (FRAC - 1));
   localparam logic signed [VW:0]         VFULL = (VW+1)'(64'sd1 <<< FRAC);

   logic [STAGES-1:0] v_ff;

   // stage 0: sin/cos rounding, fold undo, clamp; beta current rounding
   logic signed [CORDIC_W-1:0] xr, yr, xn, yn;
   logic signed [DW+21:0]      ib_wide;
   logic signed [DW-1:0]       c_in, s_in, c_ff, s_ff;
   logic signed [DW+1:0]       ib_ff;
   logic signed [DW:0]         iu0_ff;
   logic signed [DW-1:0]       ud0_ff, uq0_ff;
   // stage 1: products
   logic signed [PW-1:0]       p_iuc_ff, p_ibs_ff, p_ibc_ff, p_ius_ff;
   logic signed [PW-1:0]       p_udc_ff, p_uqs_ff, p_uqc_ff, p_uds_ff;
   // stage 2: sums and rounding
   logic signed [PW:0]         id_r, iq_r, al_r, be_r;
   logic signed [DW:0]         id_in, iq_in, id2_ff, iq2_ff;
   logic signed [DW+1:0]       al2_ff, be2_ff;
   // stage 3: sqrt3 scaling
   logic signed [DW+20:0]      sbp_ff;
   logic signed [DW+1:0]       al3_ff;
   // stage 4: phase voltages
   logic signed [DW+20:0]      sb_wide;
   logic signed [VW-1:0]       sb, al_v, va_in, vb_in, vc_in;
   logic signed [VW-1:0]       va4_ff, vb4_ff, vc4_ff;
   // stage 5: midpoint
   logic signed [VW-1:0]       mx, mn;
   logic signed [VW:0]         mid_sum;
   logic signed [VW-1:0]       mid5_ff, va5_ff, vb5_ff, vc5_ff;
   // stage 6: clamped phase duties
   logic signed [VW:0]         pa_r, pb_r, pc_r;
   logic [DW-1:0]              pa_in, pb_in, pc_in, pa6_ff, pb6_ff, pc6_ff;
   // stage 7: compare counts
   logic [DW+15:0]             da_prod, db_prod, dc_prod;
   logic [15:0]                da_ff, db_ff, dc_ff;
   // carried fields
   logic [AW-1:0]              elec_ff [STAGES];
   logic signed [DW:0]         id_c_ff [3:7];
   logic signed [DW:0]         iq_c_ff [3:7];

   function automatic logic [DW-1:0] phase_clamp(input logic signed [VW:0] p);
      logic [DW-1:0] r;
      if (p[VW]) begin
         r = '0;
      end else if (p > VFULL) begin
         r = VFULL[DW-1:0];
      end else begin
         r = p[DW-1:0];
      end
      return r;
   endfunction

   always_comb begin
      xr = (x_in + CHALF) >>> SH;
      yr = (y_in + CHALF) >>> SH;
      xn = flip ? -xr : xr;
      yn = flip ? -yr : yr;
      if (xn > CLIMP)      c_in = CLIMP[DW-1:0];
      else if (xn < CLIMN) c_in = CLIMN[DW-1:0];
      else                 c_in = xn[DW-1:0];
      if (yn > CLIMP)      s_in = CLIMP[DW-1:0];
      else if (yn < CLIMN) s_in = CLIMN[DW-1:0];
      else                 s_in = yn[DW-1:0];
      ib_wide = (ibp + BHALF) >>> 16;
   end

   always_comb begin
      id_r = ((PW+1)'(p_iuc_ff) + (PW+1)'(p_ibs_ff) + PHALF) >>> FRAC;
      iq_r = ((PW+1)'(p_ibc_ff) - (PW+1)'(p_ius_ff) + PHALF) >>> FRAC;
      al_r = ((PW+1)'(p_udc_ff) - (PW+1)'(p_uqs_ff) + PHALF) >>> FRAC;
      be_r = ((PW+1)'(p_uqc_ff) + (PW+1)'(p_uds_ff) + PHALF) >>> FRAC;
      if (id_r > ILIMP)      id_in = ILIMP[DW:0];
      else if (id_r < ILIMN) id_in = ILIMN[DW:0];
      else                   id_in = id_r[DW:0];
      if (iq_r > ILIMP)      iq_in = ILIMP[DW:0];
      else if (iq_r < ILIMN) iq_in = ILIMN[DW:0];
      else                   iq_in = iq_r[DW:0];
   end

   always_comb begin
      sb_wide = (sbp_ff + SHALF) >>> 16;
      sb      = sb_wide[VW-1:0];
      al_v    = VW'(al3_ff);
      va_in   = al_v;
      vb_in   = (sb - al_v) >>> 1;
      vc_in   = (-sb - al_v) >>> 1;
   end

   always_comb begin
      mx = va4_ff;
      mn = va4_ff;
      if (vb4_ff > mx) mx = vb4_ff;
      if (vc4_ff > mx) mx = vc4_ff;
      if (vb4_ff < mn) mn = vb4_ff;
      if (vc4_ff < mn) mn = vc4_ff;
      mid_sum = ((VW+1)'(mx) + (VW+1)'(mn)) >>> 1;
   end

   always_comb begin
      pa_r  = (VW+1)'(va5_ff) - (VW+1)'(mid5_ff) + VHALF;
      pb_r  = (VW+1)'(vb5_ff) - (VW+1)'(mid5_ff) + VHALF;
      pc_r  = (VW+1)'(vc5_ff) - (VW+1)'(mid5_ff) + VHALF;
      pa_in = phase_clamp(pa_r);
      pb_in = phase_clamp(pb_r);
      pc_in = phase_clamp(pc_r);
   end

   assign da_prod = pa6_ff * pwm_period;
   assign db_prod = pb6_ff * pwm_period;
   assign dc_prod = pc6_ff * pwm_period;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         ib_ff    <= ib_wide[DW+1:0];
         iu0_ff   <= iu;
         ud0_ff   <= ud;
         uq0_ff   <= uq;
         p_iuc_ff <= iu0_ff * c_ff;
         p_ibs_ff <= ib_ff * s_ff;
         p_ibc_ff <= ib_ff * c_ff;
         p_ius_ff <= iu0_ff * s_ff;
         p_udc_ff <= ud0_ff * c_ff;
         p_uqs_ff <= uq0_ff * s_ff;
         p_uqc_ff <= uq0_ff * c_ff;
         p_uds_ff <= ud0_ff * s_ff;
         id2_ff   <= id_in;
         iq2_ff   <= iq_in;
         al2_ff   <= al_r[DW+1:0];
         be2_ff   <= be_r[DW+1:0];
         sbp_ff   <= be2_ff * SQRT3_Q16;
         al3_ff   <= al2_ff;
         va4_ff   <= va_in;
         vb4_ff   <= vb_in;
         vc4_ff   <= vc_in;
         mid5_ff  <= mid_sum[VW-1:0];
         va5_ff   <= va4_ff;
         vb5_ff   <= vb4_ff;
         vc5_ff   <= vc4_ff;
         pa6_ff   <= pa_in;
         pb6_ff   <= pb_in;
         pc6_ff   <= pc_in;
         da_ff    <= da_prod[FRAC+15:FRAC];
         db_ff    <= db_prod[FRAC+15:FRAC];
         dc_ff    <= dc_prod[FRAC+15:FRAC];
         elec_ff[0] <= elec;
         for (int k = 1; k < STAGES; k++) begin
            elec_ff[k] <= elec_ff[k-1];
         end
         id_c_ff[3] <= id2_ff;
         iq_c_ff[3] <= iq2_ff;
         for (int k = 4; k < STAGES; k++) begin
            id_c_ff[k] <= id_c_ff[k-1];
            iq_c_ff[k] <= iq_c_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign elec_o    = elec_ff[STAGES-1];
   assign id_o      = id_c_ff[STAGES-1];
   assign iq_o      = iq_c_ff[STAGES-1];
   assign duty_a    = da_ff;
   assign duty_b    = db_ff;
   assign duty_c    = dc_ff;

   `FPCS_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(v_ff))
   `FPCS_ASSERT_NEXT(a_valid_enters, clock, reset, en && in_valid, v_ff[0])
   `FPCS_ASSERT_NOW(a_phase_clamped, clock, reset, v_ff[STAGES-2],
      (pa6_ff <= VFULL[DW-1:0]) && (pb6_ff <= VFULL[DW-1:0]) && (pc6_ff <= VFULL[DW-1:0]))

endmodule
`default_nettype wire
